@@ rtl/core/ebbs_pkg.sv @@
// Shared types, constants and codes for the event bounded block scheduler.
package ebbs_pkg;

    localparam int EVENT_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(EVENT_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_PLAN   = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic REG_MAX_BLOCK = 1'b0;
    localparam logic REG_START_POS = 1'b1;

    localparam logic [30:0] MAX_BLOCK_RESET = 31'd256;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] event_time;
        logic [31:0] frames_left;
        logic [31:0] frames_available;
    } sched_in_t;

    typedef struct packed {
        logic [31:0] block_start;
        logic [10:0] first_event_index;
        logic [10:0] events_due;
        logic [10:0] events_late;
        logic [30:0] block_length;
        logic [1:0]  status;
        logic        late_seen;
    } sched_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_LIM,
        S_LIM2,
        S_WALK,
        S_EVAL,
        S_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic append;
        logic lim1;
        logic lim2;
        logic rd;
        logic eval;
        logic fin;
        logic done;
    } cmd_t;

    typedef struct packed {
        logic more;
        logic due;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/core/event_bounded_block_scheduler.sv @@
// Top level of the event bounded block scheduler: controller and datapath.
// Append or unused opcode: append state, then done state, which registers the result when
// the output is free. Plan or commit: S_LIM, S_LIM2, then a walk that reads and evaluates
// stored event times in turn, until one is not yet due or all are read; then S_FIN, S_DONE.
// One item at a time; the next item is accepted while the previous result waits.
// Reset: position 0, block limit 256, indexes and late flag cleared; event store not cleared.
module event_bounded_block_scheduler (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ebbs_pkg::sched_in_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ebbs_pkg::sched_out_t out_data,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);
    import ebbs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ebbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (in_data.opcode),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    ebbs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ rtl/core/ebbs_ctrl.sv @@
// Controller state machine: sequences append, limit, event walk and result stages.
module ebbs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      opcode,
    input  ebbs_pkg::stat_t stat,
    output logic            in_ready,
    output ebbs_pkg::cmd_t  cmd
);
    import ebbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_PLAN || opcode == OP_COMMIT)
                    begin
                        state_next = S_LIM;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND: state_next = S_DONE;
            S_LIM:    state_next = S_LIM2;
            S_LIM2:   state_next = S_WALK;
            S_WALK:   state_next = stat.more ? S_EVAL : S_FIN;
            S_EVAL:   state_next = stat.due ? S_WALK : S_FIN;
            S_FIN:    state_next = S_DONE;
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_APPEND: cmd.append = 1'b1;
            S_LIM:    cmd.lim1   = 1'b1;
            S_LIM2:   cmd.lim2   = 1'b1;
            S_WALK:   cmd.rd     = stat.more;
            S_EVAL:   cmd.eval   = 1'b1;
            S_FIN:    cmd.fin    = 1'b1;
            S_DONE:   cmd.done   = stat.out_free;
            default:  cmd        = '0;
        endcase
    end

endmodule

@@ rtl/core/ebbs_dp.sv @@
// Datapath: event store, position and index registers, walk counters and result register.
module ebbs_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ebbs_pkg::sched_in_t  in_data,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 out_ready,
    input  ebbs_pkg::cmd_t       cmd,
    output ebbs_pkg::stat_t      stat,
    output logic                 out_valid,
    output ebbs_pkg::sched_out_t out_data
);
    import ebbs_pkg::*;

    logic [31:0]      mem [EVENT_DEPTH];
    logic [31:0]      rd_data_reg;

    logic [31:0]      pos_reg;
    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             late_flag_reg;
    logic [30:0]      mbl_reg;

    logic [1:0]       op_reg;
    logic [31:0]      ev_reg;
    logic [31:0]      left_reg;
    logic [31:0]      avail_reg;
    logic [30:0]      lim_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] late_reg;
    logic             stop_reg;
    logic [1:0]       status_reg;
    logic [30:0]      len_reg;

    logic             out_valid_reg;
    sched_out_t       out_reg;

    logic [31:0]      pos_minus_ev;
    logic [31:0]      ev_minus_pos;
    logic             full;
    logic             commit_ok;
    logic             late_any;
    logic             do_append;

    assign pos_minus_ev = pos_reg - rd_data_reg;
    assign ev_minus_pos = rd_data_reg - pos_reg;
    assign full         = (cnt_reg == CNT_W'(EVENT_DEPTH));
    assign commit_ok    = (op_reg == OP_COMMIT) && (status_reg == ST_OK);
    assign late_any     = (late_reg != '0);
    assign do_append    = cmd.append && (op_reg == OP_APPEND);

    assign stat.more     = (idx_reg < cnt_reg);
    assign stat.due      = !pos_minus_ev[31];
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (do_append && !full)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= ev_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            late_flag_reg <= 1'b0;
            mbl_reg       <= MAX_BLOCK_RESET;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MAX_BLOCK: mbl_reg <= cfg_data[30:0];
                    REG_START_POS: pos_reg <= cfg_data;
                    default:       mbl_reg <= mbl_reg;
                endcase
            end
            if (cmd.capture)
            begin
                idx_reg <= pend_reg;
            end
            if (do_append && !full)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.eval && stat.due)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.done)
            begin
                out_valid_reg <= 1'b1;
                if (commit_ok)
                begin
                    pend_reg <= idx_reg;
                    pos_reg  <= pos_reg + {1'b0, len_reg};
                    if (late_any)
                    begin
                        late_flag_reg <= 1'b1;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= in_data.opcode;
            ev_reg     <= in_data.event_time;
            left_reg   <= in_data.frames_left;
            avail_reg  <= in_data.frames_available;
            late_reg   <= '0;
            stop_reg   <= 1'b0;
            status_reg <= ST_OK;
            len_reg    <= '0;
        end
        if (do_append && full)
        begin
            status_reg <= ST_FULL;
        end
        if (cmd.lim1)
        begin
            lim_reg <= (avail_reg < {1'b0, mbl_reg}) ? avail_reg[30:0] : mbl_reg;
        end
        if (cmd.lim2)
        begin
            if (left_reg < {1'b0, lim_reg})
            begin
                lim_reg <= left_reg[30:0];
            end
        end
        if (cmd.eval)
        begin
            if (stat.due)
            begin
                if (ev_minus_pos[31])
                begin
                    late_reg <= late_reg + 1'b1;
                end
            end
            else
            begin
                stop_reg <= 1'b1;
            end
        end
        if (cmd.fin)
        begin
            if (stop_reg && ev_minus_pos[31])
            begin
                status_reg <= ST_RANGE;
                len_reg    <= '0;
            end
            else if (stop_reg && (ev_minus_pos[30:0] < lim_reg))
            begin
                len_reg <= ev_minus_pos[30:0];
            end
            else
            begin
                len_reg <= lim_reg;
            end
        end
        if (cmd.done)
        begin
            out_reg.block_start       <= pos_reg;
            out_reg.first_event_index <= pend_reg;
            out_reg.events_due        <= idx_reg - pend_reg;
            out_reg.events_late       <= late_reg;
            out_reg.block_length      <= len_reg;
            out_reg.status            <= status_reg;
            out_reg.late_seen         <= late_flag_reg || (commit_ok && late_any);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(EVENT_DEPTH))
        else $error("event count beyond store depth");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= cnt_reg)
        else $error("pending index beyond stored events");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (idx_reg >= pend_reg && idx_reg < cnt_reg))
        else $error("event read outside pending range");

    a_late_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |-> late_reg <= (idx_reg - pend_reg))
        else $error("late count exceeds due count");

endmodule

@@ tb/event_bounded_block_scheduler_tb.sv @@
// Self-checking testbench for the event bounded block scheduler.
module event_bounded_block_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ebbs_pkg::*;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [31:0] HALF_RANGE  = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam int          RANDOM_END  = 1420;
    localparam int          PHASE_ITEMS = 150;
    localparam int          HOLD_AFTER  = 600;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 3_000_000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    sched_in_t  in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    sched_out_t out_data;
    logic       cfg_write = 1'b0;
    logic       cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic       hold_off = 1'b0;

    // scheduler state as predicted from accepted transactions
    logic [31:0] cur_position = '0;
    logic [30:0] block_limit = MAX_BLOCK_RESET;
    int unsigned pend_idx = 0;
    int unsigned stored_cnt = 0;
    logic [31:0] event_times [EVENT_DEPTH];
    bit          late_flag = 1'b0;

    sched_in_t   request_queue [$];
    sched_out_t  block_reports [$];

    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_wait = 0;
    int          issued_items = 0;
    int          accepted_items = 0;
    int          checked_reports = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          reg_writes = 0;
    int          n_append = 0, n_plan = 0, n_commit = 0, n_unused = 0;
    int          n_range = 0, n_full = 0, n_late = 0, n_due = 0;

    event_bounded_block_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit precedes(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic sched_out_t plan_block(sched_in_t item);
        sched_out_t  r;
        int unsigned idx;
        int unsigned late;
        logic [31:0] limit;
        logic [31:0] span;
        logic [1:0]  st;
        r = '0;
        r.block_start = cur_position;
        r.first_event_index = 11'(pend_idx);
        st = ST_OK;
        case (item.opcode)
            OP_APPEND:
            begin
                n_append++;
                if (stored_cnt >= EVENT_DEPTH)
                begin
                    st = ST_FULL;
                    n_full++;
                end
                else
                begin
                    event_times[stored_cnt] = item.event_time;
                    stored_cnt++;
                end
            end
            OP_PLAN, OP_COMMIT:
            begin
                if (item.opcode == OP_PLAN)
                    n_plan++;
                else
                    n_commit++;
                idx = pend_idx;
                late = 0;
                while (idx < stored_cnt && !precedes(cur_position, event_times[idx]))
                begin
                    if (precedes(event_times[idx], cur_position))
                        late++;
                    idx++;
                end
                limit = {1'b0, block_limit};
                if (item.frames_available < limit)
                    limit = item.frames_available;
                if (item.frames_left < limit)
                    limit = item.frames_left;
                if (idx < stored_cnt)
                begin
                    span = event_times[idx] - cur_position;
                    if (span >= HALF_RANGE)
                    begin
                        st = ST_RANGE;
                        limit = '0;
                        n_range++;
                    end
                    else if (span < limit)
                        limit = span;
                end
                r.events_due = 11'(idx - pend_idx);
                r.events_late = 11'(late);
                r.block_length = limit[30:0];
                n_due += idx - pend_idx;
                n_late += late;
                if (item.opcode == OP_COMMIT && st == ST_OK)
                begin
                    pend_idx = idx;
                    cur_position = cur_position + limit;
                    if (late != 0)
                        late_flag = 1'b1;
                end
            end
            default:
                n_unused++;
        endcase
        r.status = st;
        r.late_seen = late_flag;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(16, 40);
    endfunction

    function automatic logic [31:0] pick_frames();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return ALL_ONES;
        if (r < 24)
            return $urandom;
        return $urandom_range(1, 600);
    endfunction

    function automatic logic [31:0] pick_offset();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 35)
            return 32'd0 - $urandom_range(1, 500);
        if (r < 85)
            return $urandom_range(1, 700);
        if (r < 94)
            return $urandom;
        if (r < 96)
            return HALF_RANGE;
        return HALF_RANGE - $urandom_range(1, 300);
    endfunction

    function automatic bit stuck_on_event();
        logic [31:0] span;
        if (pend_idx >= stored_cnt)
            return 1'b0;
        if (stored_cnt - pend_idx > 24)
            return 1'b1;
        span = event_times[pend_idx] - cur_position;
        return span >= 32'd4096 && span <= HALF_RANGE;
    endfunction

    function automatic void push_item(logic [1:0] op, logic [31:0] t, logic [31:0] left,
                                      logic [31:0] avail);
        sched_in_t it;
        it.opcode = op;
        it.event_time = t;
        it.frames_left = left;
        it.frames_available = avail;
        request_queue.push_back(it);
        issued_items++;
    endfunction

    task automatic drain_requests();
        while (!(request_queue.size() == 0 && !in_valid))
            @(posedge clk);
    endtask

    task automatic settle();
        while (!(request_queue.size() == 0 && !in_valid && block_reports.size() == 0))
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        settle();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_MAX_BLOCK)
            block_limit = value[30:0];
        else
            cur_position = value;
        reg_writes++;
    endtask

    task automatic check_report(input sched_out_t got);
        sched_out_t want;
        string      wrong;
        if (block_reports.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result with nothing expected: start=%h len=%h status=%0d",
                         got.block_start, got.block_length, got.status);
        end
        else
        begin
            want = block_reports.pop_front();
            checked_reports++;
            wrong = "";
            if (got.block_start !== want.block_start)
                wrong = {wrong, " block_start"};
            if (got.first_event_index !== want.first_event_index)
                wrong = {wrong, " first_event_index"};
            if (got.events_due !== want.events_due)
                wrong = {wrong, " events_due"};
            if (got.events_late !== want.events_late)
                wrong = {wrong, " events_late"};
            if (got.block_length !== want.block_length)
                wrong = {wrong, " block_length"};
            if (got.status !== want.status)
                wrong = {wrong, " status"};
            if (got.late_seen !== want.late_seen)
                wrong = {wrong, " late_seen"};
            if (wrong != "")
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("mismatch on result %0d:%s", checked_reports, wrong);
                    $display("  expected start=%h first=%0d due=%0d late=%0d len=%h st=%0d ls=%0d",
                             want.block_start, want.first_event_index, want.events_due,
                             want.events_late, want.block_length, want.status, want.late_seen);
                    $display("  actual   start=%h first=%0d due=%0d late=%0d len=%h st=%0d ls=%0d",
                             got.block_start, got.first_event_index, got.events_due,
                             got.events_late, got.block_length, got.status, got.late_seen);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                block_reports.push_back(plan_block(in_data));
                accepted_items++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end
                else if (request_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_queue.pop_front();
                    if ($urandom_range(0, 47) == 0)
                        tx_steady = !tx_steady;
                    tx_gap <= tx_steady ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned g;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_report(out_data);
            if (hold_off)
                out_ready <= 1'b0;
            else if (rx_wait != 0)
            begin
                out_ready <= 1'b0;
                rx_wait   <= rx_wait - 1;
            end
            else if (out_valid && out_ready)
            begin
                if ($urandom_range(0, 47) == 0)
                    rx_steady = !rx_steady;
                g = rx_steady ? 0 : pick_gap();
                out_ready <= (g == 0);
                rx_wait   <= (g == 0) ? 0 : g - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // hold the result side off long enough for the block to back up its input
    initial
    begin
        wait (accepted_items >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, block_reports.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int          next_phase;
        int          n;
        int unsigned r;
        logic [31:0] value;
        logic [31:0] base;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        push_item(OP_PLAN, '0, ALL_ONES, ALL_ONES);
        push_item(OP_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);
        push_item(OP_APPEND, 32'd0, '0, '0);
        push_item(OP_APPEND, 32'd100, '0, '0);
        push_item(OP_APPEND, ALL_ONES, '0, '0);
        push_item(OP_COMMIT, '0, 32'd1000, ALL_ONES);
        push_item(OP_COMMIT, '0, '0, 32'd1000);
        push_item(OP_COMMIT, '0, ALL_ONES, '0);
        push_item(OP_APPEND, HALF_RANGE + 32'd100, '0, '0);
        push_item(OP_PLAN, '0, ALL_ONES, ALL_ONES);
        push_item(OP_COMMIT, '0, ALL_ONES, ALL_ONES);
        write_reg(REG_MAX_BLOCK, '0);
        write_reg(REG_START_POS, HALF_RANGE + 32'd100);
        push_item(OP_COMMIT, '0, ALL_ONES, ALL_ONES);
        write_reg(REG_MAX_BLOCK, 32'h7FFF_FFFF);
        push_item(OP_APPEND, HALF_RANGE + 32'd105, '0, '0);
        push_item(OP_COMMIT, '0, ALL_ONES, ALL_ONES);
        push_item(OP_COMMIT, '0, ALL_ONES, ALL_ONES);
        push_item(OP_PLAN, ALL_ONES, ALL_ONES, ALL_ONES);
        write_reg(REG_START_POS, ALL_ONES);
        push_item(OP_APPEND, 32'd2, '0, '0);
        push_item(OP_COMMIT, '0, ALL_ONES, ALL_ONES);
        push_item(OP_COMMIT, '0, ALL_ONES, ALL_ONES);
        write_reg(REG_MAX_BLOCK, 32'({1'b0, MAX_BLOCK_RESET}));

        next_phase = issued_items + PHASE_ITEMS;
        while (issued_items < RANDOM_END)
        begin
            drain_requests();
            if (issued_items >= next_phase)
            begin
                next_phase = issued_items + PHASE_ITEMS;
                r = $urandom_range(0, 3);
                case (r)
                    0: value = 32'd1;
                    1: value = 32'h7FFF_FFFF;
                    2: value = $urandom_range(2, 1000);
                    default: value = 32'd256;
                endcase
                write_reg(REG_MAX_BLOCK, value);
                if ($urandom_range(0, 2) == 0)
                begin
                    r = $urandom_range(0, 2);
                    value = (r == 0) ? 32'd0 : (r == 1) ? ALL_ONES : 32'($urandom);
                    write_reg(REG_START_POS, value);
                end
            end
            else if (stuck_on_event())
                write_reg(REG_START_POS, event_times[pend_idx] - $urandom_range(0, 40));

            if ($urandom_range(0, 99) < 10)
            begin
                n = $urandom_range(1, 3);
                repeat (n) push_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            end
            else
            begin
                n = $urandom_range(0, 4);
                repeat (n) push_item(OP_APPEND, cur_position + pick_offset(), $urandom, $urandom);
                n = $urandom_range(1, 4);
                repeat (n)
                    push_item(($urandom_range(0, 3) == 0) ? OP_PLAN : OP_COMMIT, $urandom,
                              pick_frames(), pick_frames());
            end
        end

        // fill the event store past capacity
        drain_requests();
        base = cur_position;
        n = EVENT_DEPTH - stored_cnt + 6;
        for (int i = 0; i < n; i++)
        begin
            push_item(OP_APPEND, base, $urandom, $urandom);
            if (i % 8 == 7)
                push_item(OP_COMMIT, $urandom, '0, pick_frames());
        end
        repeat (6)
            push_item(($urandom_range(0, 1) == 0) ? OP_PLAN : OP_COMMIT, $urandom,
                      pick_frames(), pick_frames());

        settle();
        repeat (64) @(posedge clk);
        fail_count += block_reports.size();

        $display("covered %0d transactions: %0d appends, %0d plans, %0d commits, %0d unused op",
                 accepted_items, n_append, n_plan, n_commit, n_unused);
        $display("%0d results checked, %0d due events (%0d late), %0d half range, %0d store full, %0d register writes",
                 checked_reports, n_due, n_late, n_range, n_full, reg_writes);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
